// File: rtl/tlb_pkg.sv
// ----------------------------------------------------------------------------
// tlb_pkg - shared types and constants of the two-level token bucket limiter
// Field widths, fixed-point format, operation and register codes, the entry
// row layout and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tlb_pkg;

  // Fixed-point and field widths
  localparam int FRAC_BITS  = 16;
  localparam int TIME_BITS  = 48;
  localparam int VAL_W      = 40;
  localparam int LVL_W      = VAL_W + FRAC_BITS;
  localparam int SIZE_W     = 32;
  localparam int TOT_W      = 64;
  localparam int ACT_W      = 7;
  localparam int OP_W       = 3;
  localparam int IDX_W      = 6;
  localparam int CFG_IDX_W  = 3;

  // Multiplier split: rate is taken in two halves
  localparam int HALF_W     = VAL_W / 2;
  localparam int PP_W       = TIME_BITS + HALF_W;
  localparam int PROD_W     = TIME_BITS + VAL_W;

  // Stream word widths
  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 216;

  // Register reset values
  localparam logic [VAL_W-1:0] RST_GLOBAL_RATE  = 40'd6553600;
  localparam logic [VAL_W-1:0] RST_GLOBAL_BURST = 40'd200000000;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_SET    = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLOBAL_RATE  = 3'd0,
    CFG_GLOBAL_BURST = 3'd1,
    CFG_DEF_RD_RATE  = 3'd2,
    CFG_DEF_WR_RATE  = 3'd3,
    CFG_DEF_BURST    = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_G_MUL_LO,
    S_G_MUL_HI,
    S_G_SUM,
    S_G_CAP,
    S_G_TAKE,
    S_E_MUL_LO,
    S_E_MUL_HI,
    S_E_SUM,
    S_E_CAP,
    S_E_TAKE,
    S_APPLY,
    S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_LOAD,
    STEP_MUL_LO,
    STEP_MUL_HI,
    STEP_SUM,
    STEP_CAP,
    STEP_G_TAKE,
    STEP_E_TAKE,
    STEP_APPLY,
    STEP_EMIT
  } step_t;

  typedef struct packed {
    step_t step;
    logic  entry;   // refill operands come from the entry bucket
  } cmd_t;

  typedef struct packed {
    logic is_req;   // word on the input is an in-range read or write request
    logic g_pass;   // bucket level covers the request cost
    logic out_busy; // output register holds a word not yet taken
  } stat_t;

  typedef struct packed {
    logic [VAL_W-1:0]     rd_rate;
    logic [VAL_W-1:0]     wr_rate;
    logic [VAL_W-1:0]     burst;
    logic [LVL_W-1:0]     rd_level;
    logic [LVL_W-1:0]     wr_level;
    logic [TIME_BITS-1:0] rd_stamp;
    logic [TIME_BITS-1:0] wr_stamp;
    logic [TOT_W-1:0]     rd_total;
    logic [TOT_W-1:0]     wr_total;
  } row_t;

endpackage

// File: rtl/two_level_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// two_level_token_bucket_limiter - read/write policer with global and
// per-entry token buckets
// Polices each request against the global bucket of its direction and then
// against the addressed entry's bucket, refunding the global tokens when the
// entry bucket refuses. Buckets refill lazily, time moves only on tick words.
// ----------------------------------------------------------------------------
// One word is handled at a time. Tick, set limit, remove, unknown operations
// and out-of-range indexes pass through the apply step only; a request refused
// by the global bucket stops after the global take, and a request that reaches
// the entry bucket goes on through the entry refill and take. Each bucket
// refill uses the shared 48x20 refill multiplier twice, once per rate half,
// followed by the product sum, the cap clamp and the take. A result word
// waits in the output register; the emit step stalls until that register is
// free. The entry table has one write port and one registered read port, is
// read as the word is loaded and is written back at most once per word.
// Configuration is always ready.
module two_level_token_bucket_limiter #(
  parameter int NUM_ALLOCATIONS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tlb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlb_pkg::VAL_W-1:0]         cfg_data,
  // Input words
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // alloc_index[5:0], request_size[37:6], new_read_rate[77:38],
  // new_write_rate[117:78], new_burst[157:118], zero fill [159:158]
  input  logic [tlb_pkg::IN_TDATA_W-1:0]    in_tdata,
  // operation[2:0]
  input  logic [tlb_pkg::OP_W-1:0]          in_tuser,
  // Result words
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // granted[0], entry_bytes_read[64:1], entry_bytes_written[128:65],
  // global_read_available[168:129], global_write_available[208:169],
  // live_entries[215:209]
  output logic [tlb_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import tlb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlb_dp #(
    .NUM_ALLOCATIONS (NUM_ALLOCATIONS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// File: rtl/tlb_ctrl.sv
// ----------------------------------------------------------------------------
// tlb_ctrl - sequencing controller of the token bucket limiter
// Walks each request through global refill, global take and, if that passes,
// entry refill and entry take; other words go through a single apply step; then hands the result out.
// ----------------------------------------------------------------------------
module tlb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  tlb_pkg::stat_t  stat,
  output tlb_pkg::cmd_t   cmd
);
  import tlb_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = stat.is_req ? S_G_MUL_LO : S_APPLY;
        end
      end
      S_G_MUL_LO: state_nxt = S_G_MUL_HI;
      S_G_MUL_HI: state_nxt = S_G_SUM;
      S_G_SUM:    state_nxt = S_G_CAP;
      S_G_CAP:    state_nxt = S_G_TAKE;
      S_G_TAKE:   state_nxt = stat.g_pass ? S_E_MUL_LO : S_EMIT;
      S_E_MUL_LO: state_nxt = S_E_MUL_HI;
      S_E_MUL_HI: state_nxt = S_E_SUM;
      S_E_SUM:    state_nxt = S_E_CAP;
      S_E_CAP:    state_nxt = S_E_TAKE;
      S_E_TAKE:   state_nxt = S_EMIT;
      S_APPLY:    state_nxt = S_EMIT;
      S_EMIT: begin
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd.step  = STEP_NONE;
    cmd.entry = 1'b0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.step = STEP_LOAD;
        end
      end
      S_G_MUL_LO: cmd.step = STEP_MUL_LO;
      S_G_MUL_HI: cmd.step = STEP_MUL_HI;
      S_G_SUM:    cmd.step = STEP_SUM;
      S_G_CAP:    cmd.step = STEP_CAP;
      S_G_TAKE:   cmd.step = STEP_G_TAKE;
      S_E_MUL_LO: begin
        cmd.step  = STEP_MUL_LO;
        cmd.entry = 1'b1;
      end
      S_E_MUL_HI: begin
        cmd.step  = STEP_MUL_HI;
        cmd.entry = 1'b1;
      end
      S_E_SUM: begin
        cmd.step  = STEP_SUM;
        cmd.entry = 1'b1;
      end
      S_E_CAP: begin
        cmd.step  = STEP_CAP;
        cmd.entry = 1'b1;
      end
      S_E_TAKE: begin
        cmd.step  = STEP_E_TAKE;
        cmd.entry = 1'b1;
      end
      S_APPLY:    cmd.step = STEP_APPLY;
      S_EMIT:     cmd.step = STEP_EMIT;
      default:    cmd.step = STEP_NONE;
    endcase
  end

  // An accepted word is never followed by another in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word accepted while one is in progress");

  // The global take only leads to an entry refill or to the result
  a_g_take_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_G_TAKE) |=> (state_r == S_E_MUL_LO || state_r == S_EMIT))
    else $error("bad exit from global take");

  // Entry take always leads straight to the result
  a_e_take_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_E_TAKE) |=> (state_r == S_EMIT))
    else $error("bad exit from entry take");

endmodule

// File: rtl/tlb_dp.sv
// ----------------------------------------------------------------------------
// tlb_dp - datapath of the token bucket limiter
// Configuration registers, global buckets, tick counter, entry table memory
// with presence flags, shared refill unit and the output register.
// ----------------------------------------------------------------------------
module tlb_dp #(
  parameter int NUM_ALLOCATIONS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tlb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlb_pkg::VAL_W-1:0]         cfg_data,
  input  logic [tlb_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [tlb_pkg::OP_W-1:0]          in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tlb_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  tlb_pkg::cmd_t                     cmd,
  output tlb_pkg::stat_t                    stat
);
  import tlb_pkg::*;

  localparam int AW    = (NUM_ALLOCATIONS > 1) ? $clog2(NUM_ALLOCATIONS) : 1;
  localparam int CNT_W = $clog2(NUM_ALLOCATIONS + 1);

  // Configuration registers
  logic [VAL_W-1:0] g_rate_r, g_burst_r, d_rd_rate_r, d_wr_rate_r, d_burst_r;

  // Global state
  logic [TIME_BITS-1:0] tick_r;
  logic [LVL_W-1:0]     g_level_r [2];
  logic [TIME_BITS-1:0] g_stamp_r [2];

  // Entry flags
  logic [NUM_ALLOCATIONS-1:0] present_r, rbp_r, wbp_r, rtv_r, wtv_r;
  logic [CNT_W-1:0]           cnt_r;

  // Word under work
  logic [OP_W-1:0]   op_r;
  logic [AW-1:0]     addr_r;
  logic              ok_r;
  logic [SIZE_W-1:0] size_r;
  logic [VAL_W-1:0]  nrr_r, nwr_r, nb_r;

  // Refill unit
  logic [PP_W-1:0]  p_lo_r, p_hi_r;
  logic [LVL_W-1:0] add_r, lvl_r;
  logic             sat_r;

  // Result
  logic              granted_r;
  logic [TOT_W-1:0]  res_rtot_r, res_wtot_r;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // Entry table
  row_t mem [NUM_ALLOCATIONS];
  row_t rd_r;
  row_t wr_row;
  logic mem_we;
  logic [AW-1:0] rd_addr;

  // Input decode
  logic [IDX_W-1:0]  in_idx;
  logic [OP_W-1:0]   in_op;
  logic              in_ok;
  logic [AW-1:0]     in_addr;

  assign in_op   = in_tuser;
  assign in_idx  = in_tdata[5:0];
  assign in_ok   = ({26'd0, in_idx} < 32'(NUM_ALLOCATIONS));
  assign in_addr = AW'(in_idx);

  assign stat.is_req = in_ok && (in_op == OP_READ || in_op == OP_WRITE);

  // Operand selection
  logic                 dir;
  logic                 bp;
  logic [VAL_W-1:0]     e_rate, e_burst, src_rate;
  logic [LVL_W-1:0]     e_level, src_level, src_cap, g_cap, cost;
  logic [TIME_BITS-1:0] e_stamp, src_stamp, elapsed;
  logic [TOT_W-1:0]     cur_rtot, cur_wtot, new_rtot, new_wtot;

  assign dir      = (op_r == OP_WRITE);
  assign bp       = dir ? wbp_r[addr_r] : rbp_r[addr_r];
  assign g_cap    = LVL_W'(g_burst_r) << FRAC_BITS;
  assign cost     = LVL_W'(size_r) << FRAC_BITS;
  assign cur_rtot = (ok_r && rtv_r[addr_r]) ? rd_r.rd_total : '0;
  assign cur_wtot = (ok_r && wtv_r[addr_r]) ? rd_r.wr_total : '0;

  // Missing bucket reads as newly created, full
  always_comb begin
    if (bp) begin
      e_rate  = dir ? rd_r.wr_rate  : rd_r.rd_rate;
      e_burst = rd_r.burst;
      e_level = dir ? rd_r.wr_level : rd_r.rd_level;
      e_stamp = dir ? rd_r.wr_stamp : rd_r.rd_stamp;
    end else begin
      e_rate  = dir ? d_wr_rate_r : d_rd_rate_r;
      e_burst = d_burst_r;
      e_level = LVL_W'(d_burst_r) << FRAC_BITS;
      e_stamp = tick_r;
    end
  end

  assign src_rate  = cmd.entry ? e_rate  : g_rate_r;
  assign src_level = cmd.entry ? e_level : g_level_r[dir];
  assign src_stamp = cmd.entry ? e_stamp : g_stamp_r[dir];
  assign src_cap   = cmd.entry ? (LVL_W'(e_burst) << FRAC_BITS) : g_cap;
  assign elapsed   = tick_r - src_stamp;

  // Shared multiplier: elapsed times one half of the rate
  logic [HALF_W-1:0] mul_b;
  logic [PP_W-1:0]   mul_p;
  assign mul_b = (cmd.step == STEP_MUL_HI) ? src_rate[VAL_W-1:HALF_W]
                                           : src_rate[HALF_W-1:0];
  assign mul_p = PP_W'(elapsed) * PP_W'(mul_b);

  // Combine partial products, flag saturation
  logic [PROD_W-1:0] prod;
  assign prod = PROD_W'(p_lo_r) + (PROD_W'(p_hi_r) << HALF_W);

  // Add refill, clamp at the cap
  logic [LVL_W:0]   fill_sum;
  logic             fill_full;
  logic [LVL_W-1:0] fill_level;
  assign fill_sum   = (LVL_W+1)'(src_level) + (LVL_W+1)'(add_r);
  assign fill_full  = (src_level >= src_cap) || sat_r || (fill_sum >= (LVL_W+1)'(src_cap));
  assign fill_level = fill_full ? src_cap : fill_sum[LVL_W-1:0];

  // Take the cost
  logic             pass;
  logic [LVL_W-1:0] take_level;
  assign pass       = (lvl_r >= cost);
  assign take_level = pass ? (lvl_r - cost) : lvl_r;
  assign stat.g_pass = pass;

  // Refund to the global bucket, clamped at its cap
  logic [LVL_W:0]   ref_sum;
  logic [LVL_W-1:0] ref_level;
  assign ref_sum   = (LVL_W+1)'(g_level_r[dir]) + (LVL_W+1)'(cost);
  assign ref_level = ((g_level_r[dir] >= g_cap) || (ref_sum >= (LVL_W+1)'(g_cap)))
                   ? g_cap : ref_sum[LVL_W-1:0];

  assign new_rtot = cur_rtot + ((pass && !dir) ? TOT_W'(size_r) : '0);
  assign new_wtot = cur_wtot + ((pass &&  dir) ? TOT_W'(size_r) : '0);

  // Build the row to write back
  always_comb begin
    wr_row = rd_r;
    mem_we = 1'b0;
    if (cmd.step == STEP_E_TAKE) begin
      mem_we         = 1'b1;
      wr_row.burst   = e_burst;
      wr_row.rd_total = new_rtot;
      wr_row.wr_total = new_wtot;
      if (dir) begin
        wr_row.wr_rate  = e_rate;
        wr_row.wr_level = take_level;
        wr_row.wr_stamp = tick_r;
      end else begin
        wr_row.rd_rate  = e_rate;
        wr_row.rd_level = take_level;
        wr_row.rd_stamp = tick_r;
      end
    end else if (cmd.step == STEP_APPLY && ok_r && op_r == OP_SET) begin
      mem_we          = 1'b1;
      wr_row.rd_rate  = nrr_r;
      wr_row.wr_rate  = nwr_r;
      wr_row.burst    = nb_r;
      wr_row.rd_level = LVL_W'(nb_r) << FRAC_BITS;
      wr_row.wr_level = LVL_W'(nb_r) << FRAC_BITS;
      wr_row.rd_stamp = tick_r;
      wr_row.wr_stamp = tick_r;
      wr_row.rd_total = cur_rtot;
      wr_row.wr_total = cur_wtot;
    end
  end

  // Entry table: one write port, one registered read port
  assign rd_addr = (cmd.step == STEP_LOAD) ? in_addr : addr_r;
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= wr_row;
    end
    rd_r <= mem[rd_addr];
  end

  // Configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_rate_r    <= RST_GLOBAL_RATE;
      g_burst_r   <= RST_GLOBAL_BURST;
      d_rd_rate_r <= '0;
      d_wr_rate_r <= '0;
      d_burst_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GLOBAL_RATE:  g_rate_r    <= cfg_data;
        CFG_GLOBAL_BURST: g_burst_r   <= cfg_data;
        CFG_DEF_RD_RATE:  d_rd_rate_r <= cfg_data;
        CFG_DEF_WR_RATE:  d_wr_rate_r <= cfg_data;
        CFG_DEF_BURST:    d_burst_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latch the word and run the refill unit
  always_ff @(posedge clk) begin
    case (cmd.step)
      STEP_LOAD: begin
        op_r      <= in_op;
        addr_r    <= in_addr;
        ok_r      <= in_ok;
        size_r    <= in_tdata[37:6];
        nrr_r     <= in_tdata[77:38];
        nwr_r     <= in_tdata[117:78];
        nb_r      <= in_tdata[157:118];
        granted_r <= 1'b0;
      end
      STEP_MUL_LO: p_lo_r <= mul_p;
      STEP_MUL_HI: p_hi_r <= mul_p;
      STEP_SUM: begin
        add_r <= prod[LVL_W-1:0];
        sat_r <= |prod[PROD_W-1:LVL_W];
      end
      STEP_CAP: lvl_r <= fill_level;
      STEP_G_TAKE: begin
        res_rtot_r <= cur_rtot;
        res_wtot_r <= cur_wtot;
      end
      STEP_E_TAKE: begin
        granted_r  <= pass;
        res_rtot_r <= new_rtot;
        res_wtot_r <= new_wtot;
      end
      STEP_APPLY: begin
        if (ok_r && op_r == OP_REMOVE) begin
          res_rtot_r <= '0;
          res_wtot_r <= '0;
        end else begin
          res_rtot_r <= cur_rtot;
          res_wtot_r <= cur_wtot;
        end
      end
      default: ;
    endcase
  end

  // Global buckets, time and entry flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      g_level_r[0] <= LVL_W'(RST_GLOBAL_BURST) << FRAC_BITS;
      g_level_r[1] <= LVL_W'(RST_GLOBAL_BURST) << FRAC_BITS;
      g_stamp_r[0] <= '0;
      g_stamp_r[1] <= '0;
      present_r    <= '0;
      rbp_r        <= '0;
      wbp_r        <= '0;
      rtv_r        <= '0;
      wtv_r        <= '0;
      cnt_r        <= '0;
    end else begin
      case (cmd.step)
        STEP_G_TAKE: begin
          g_level_r[dir] <= take_level;
          g_stamp_r[dir] <= tick_r;
        end
        STEP_E_TAKE: begin
          if (!pass) begin
            g_level_r[dir] <= ref_level;
          end
          if (!present_r[addr_r]) begin
            cnt_r <= cnt_r + 1'b1;
          end
          present_r[addr_r] <= 1'b1;
          rtv_r[addr_r]     <= 1'b1;
          wtv_r[addr_r]     <= 1'b1;
          if (dir) begin
            wbp_r[addr_r] <= 1'b1;
          end else begin
            rbp_r[addr_r] <= 1'b1;
          end
        end
        STEP_APPLY: begin
          if (op_r == OP_TICK) begin
            tick_r <= tick_r + 1'b1;
          end else if (ok_r && op_r == OP_SET) begin
            if (!present_r[addr_r]) begin
              cnt_r <= cnt_r + 1'b1;
            end
            present_r[addr_r] <= 1'b1;
            rbp_r[addr_r]     <= 1'b1;
            wbp_r[addr_r]     <= 1'b1;
            rtv_r[addr_r]     <= 1'b1;
            wtv_r[addr_r]     <= 1'b1;
          end else if (ok_r && op_r == OP_REMOVE) begin
            if (present_r[addr_r]) begin
              cnt_r <= cnt_r - 1'b1;
            end
            present_r[addr_r] <= 1'b0;
            rbp_r[addr_r]     <= 1'b0;
            wbp_r[addr_r]     <= 1'b0;
            rtv_r[addr_r]     <= 1'b0;
            wtv_r[addr_r]     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  assign stat.out_busy = out_valid_r && !out_tready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step == STEP_EMIT && !stat.out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == STEP_EMIT && !stat.out_busy) begin
      out_data_r <= {ACT_W'(cnt_r),
                     g_level_r[1][LVL_W-1:FRAC_BITS],
                     g_level_r[0][LVL_W-1:FRAC_BITS],
                     res_wtot_r, res_rtot_r, granted_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Entry count follows the presence flags
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(present_r)))
    else $error("entry count out of step with presence flags");

  // A bucket exists only for a present entry
  a_bucket_in_entry: assert property (@(posedge clk) disable iff (!rst_n)
    ((rbp_r | wbp_r) & ~present_r) == '0)
    else $error("bucket flag set on an absent entry");

  // A grant is only ever produced by an entry take
  a_grant_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(granted_r) |-> $past(cmd.step == STEP_E_TAKE))
    else $error("grant raised outside entry take");

endmodule
